### design/olist_pkg.sv
// Shared operation codes, status codes and cell control struct for the ordered list engine.
`default_nettype none
package olist_pkg;

  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_PREPEND   = 3'd1;
  localparam logic [2:0] OP_SORTED    = 3'd2;
  localparam logic [2:0] OP_REMOVE    = 3'd3;
  localparam logic [2:0] OP_POP_FIRST = 3'd4;
  localparam logic [2:0] OP_POP_LAST  = 3'd5;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_PREPEND = 2'd1;
  localparam logic [1:0] MODE_SORTED  = 2'd2;

  typedef struct packed {
    logic       ins_en;
    logic [1:0] ins_mode;
    logic       rem_en;
    logic       shl_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### design/olist_cell.sv
// One list cell: holds an entry, compares it with the item value and shifts with its neighbors.
`default_nettype none
module olist_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter bit IS_HEAD     = 1'b0,
  parameter bit IS_TAIL     = 1'b0
) (
  input  wire                        clk,
  input  olist_pkg::cell_ctrl_t      ctrl_i,
  input  wire                        occ_i,
  input  wire signed [VALUE_WIDTH-1:0] item_i,
  input  wire signed [VALUE_WIDTH-1:0] left_i,
  input  wire signed [VALUE_WIDTH-1:0] right_i,
  input  wire                        ins_before_i,
  input  wire                        rem_before_i,
  output logic                       ins_o,
  output logic                       rem_o,
  output logic signed [VALUE_WIDTH-1:0] val_o
);
  import olist_pkg::*;

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic signed [VALUE_WIDTH-1:0] val_nxt;
  logic                          hit;
  logic                          found;
  logic [VALUE_WIDTH-1:0]        right_sel;

  assign val_o     = val_r;
  assign found     = occ_i && (val_r == item_i);
  assign rem_o     = rem_before_i || found;
  assign ins_o     = ins_before_i || hit;
  assign right_sel = IS_TAIL ? val_r : right_i;

  always_comb begin
    unique case (ctrl_i.ins_mode)
      MODE_APPEND:  hit = !occ_i;
      MODE_PREPEND: hit = IS_HEAD;
      MODE_SORTED: begin
        if (IS_HEAD) hit = !occ_i || (item_i < val_r);
        else         hit = !occ_i || !(val_r < item_i);
      end
      default:      hit = 1'b0;
    endcase
  end

  always_comb begin
    val_nxt = val_r;
    if (ctrl_i.ins_en) begin
      if (ins_before_i) val_nxt = left_i;
      else if (hit)     val_nxt = item_i;
    end else if (ctrl_i.rem_en) begin
      if (rem_o) val_nxt = right_sel;
    end else if (ctrl_i.shl_en) begin
      val_nxt = right_sel;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

### design/ordered_list_engine.sv
// Top level of the ordered list engine: item decode, cell chain, count and result register.
//
// Bounded list of signed entries held in a row of cells, cell 0 being the head.
// Input channel: in_tuser carries the operation (append, prepend, sorted insert,
// remove value, pop first, pop last), in_tdata the value. Result channel: one
// item per input item with the popped entry, a status code and the entry count.
// An item accepted at one edge has its result valid after that edge. Throughput
// is one item per cycle unless stalled; every cell compares and shifts in the
// same cycle, with one-bit insert and remove chains running from head to tail.
// in_tready is high while the result register is empty or being taken, so a
// stalled receiver holds the result and blocks new items, none is lost.
// Reset empties the list and drops any waiting result; cell contents are not
// cleared, since no cell beyond the count is ever read.
`default_nettype none
module ordered_list_engine #(
  parameter int LIST_DEPTH  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] item_value
  input  wire  [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata   // [31:0] popped_value, [33:32] status, [38:34] entry_count
);
  import olist_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);

  logic                          fire;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic [CW-1:0]                 last_idx;
  logic                          full;
  logic                          empty;
  logic [2:0]                    op;
  logic signed [63:0]            item64;
  logic signed [VALUE_WIDTH-1:0] item_v;
  cell_ctrl_t                    ctrl;
  cell_ctrl_t                    ctrl_en;
  logic signed [VALUE_WIDTH-1:0] vals [LIST_DEPTH];
  logic [LIST_DEPTH:0]           ins_chain;
  logic [LIST_DEPTH:0]           rem_chain;
  logic signed [VALUE_WIDTH-1:0] popped_v;
  logic signed [63:0]            popped64;
  logic [1:0]                    status;
  logic                          out_tvalid_r;
  logic [31:0]                   popped_r;
  logic [1:0]                    status_r;
  logic [4:0]                    count_out_r;

  assign fire      = in_tvalid && in_tready;
  assign in_tready = !out_tvalid_r || out_tready;
  assign op        = in_tuser;
  assign item64    = 64'(signed'(in_tdata));
  assign item_v    = item64[VALUE_WIDTH-1:0];
  assign full      = (count_r == CW'(LIST_DEPTH));
  assign empty     = (count_r == '0);
  assign last_idx  = count_r - CW'(1);
  assign ins_chain[0] = 1'b0;
  assign rem_chain[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      olist_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .IS_HEAD     (gi == 0),
        .IS_TAIL     (gi == LIST_DEPTH - 1)
      ) u_cell (
        .clk          (clk),
        .ctrl_i       (ctrl_en),
        .occ_i        (CW'(gi) < count_r),
        .item_i       (item_v),
        .left_i       (vals[(gi == 0) ? 0 : gi - 1]),
        .right_i      (vals[(gi == LIST_DEPTH - 1) ? gi : gi + 1]),
        .ins_before_i (ins_chain[gi]),
        .rem_before_i (rem_chain[gi]),
        .ins_o        (ins_chain[gi+1]),
        .rem_o        (rem_chain[gi+1]),
        .val_o        (vals[gi])
      );
    end
  endgenerate

  always_comb begin
    ctrl      = '0;
    count_nxt = count_r;
    status    = ST_DONE;
    popped_v  = '0;
    unique case (op)
      OP_APPEND, OP_PREPEND, OP_SORTED: begin
        ctrl.ins_mode = (op == OP_APPEND)  ? MODE_APPEND :
                        (op == OP_PREPEND) ? MODE_PREPEND : MODE_SORTED;
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins_en = 1'b1;
          count_nxt   = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        ctrl.rem_en = 1'b1;
        if (rem_chain[LIST_DEPTH]) count_nxt = count_r - CW'(1);
        else                       status    = ST_MISS;
      end
      OP_POP_FIRST: begin
        if (empty) begin
          status = ST_MISS;
        end else begin
          ctrl.shl_en = 1'b1;
          popped_v    = vals[0];
          count_nxt   = count_r - CW'(1);
        end
      end
      OP_POP_LAST: begin
        if (empty) begin
          status = ST_MISS;
        end else begin
          popped_v  = vals[last_idx[IW-1:0]];
          count_nxt = count_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign popped64 = 64'(popped_v);

  always_comb begin
    ctrl_en = ctrl;
    if (!fire) begin
      ctrl_en.ins_en = 1'b0;
      ctrl_en.rem_en = 1'b0;
      ctrl_en.shl_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      popped_r    <= popped64[31:0];
      status_r    <= status;
      count_out_r <= 5'(count_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, count_out_r, status_r, popped_r};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    fire && full && (op == OP_APPEND || op == OP_PREPEND || op == OP_SORTED)
    |=> (count_r == $past(count_r)) && (out_tdata[33:32] == ST_FULL))
    else $error("insert into full list changed the count");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid && (out_tdata[38:34] == 5'($past(count_nxt))))
    else $error("result not presented after accepted item");
`endif

endmodule
`default_nettype wire

### dv/ordered_list_checker.sv
// Checker for the ordered list engine: tracks the list, predicts each result item and compares.
module ordered_list_checker #(
  parameter int LIST_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] item_value
  input  wire  [2:0]  in_tuser,   // [2:0] operation
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [39:0] out_tdata,  // [31:0] popped_value, [33:32] status, [38:34] entry_count
  output int          error_count,
  output int          pending_count
);
  import olist_pkg::*;

  typedef struct packed {
    logic [4:0]  entry_count;
    logic [1:0]  status;
    logic [31:0] popped_value;
  } list_result_t;

  logic signed [31:0] list_cells[$];
  list_result_t       expected_results[$];
  list_result_t       want;
  list_result_t       got;

  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic signed [31:0] value);
    list_result_t res;
    int           pos;
    res = '0;
    res.status = ST_DONE;
    case (op)
      OP_APPEND, OP_PREPEND, OP_SORTED: begin
        if (list_cells.size() >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (op == OP_APPEND) begin
          list_cells.push_back(value);
        end else if (op == OP_PREPEND) begin
          list_cells.push_front(value);
        end else if (list_cells.size() == 0 || value < list_cells[0]) begin
          list_cells.push_front(value);
        end else begin
          pos = 1;
          while (pos < list_cells.size() && list_cells[pos] < value) pos++;
          list_cells.insert(pos, value);
        end
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < list_cells.size() && list_cells[pos] != value) pos++;
        if (pos < list_cells.size()) begin
          list_cells.delete(pos);
        end else begin
          res.status = ST_MISS;
        end
      end
      OP_POP_FIRST, OP_POP_LAST: begin
        if (list_cells.size() == 0) begin
          res.status = ST_MISS;
        end else if (op == OP_POP_FIRST) begin
          res.popped_value = list_cells.pop_front();
        end else begin
          res.popped_value = list_cells.pop_back();
        end
      end
      default: begin
      end
    endcase
    res.entry_count = 5'(list_cells.size());
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_cells.delete();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation pending: %h", out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          got  = out_tdata[38:0];
          if (got.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0d, actual %0d",
                   $signed(want.popped_value), $signed(got.popped_value));
            error_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   got.entry_count);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_list_op(in_tuser, in_tdata));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

### dv/ordered_list_engine_test.sv
// Testbench top for the ordered list engine: clock, reset, stimulus, receiver stalls and verdict.
module ordered_list_engine_test;
  import olist_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_START     = 800;
  localparam int HOLD_LEN       = 300;

  typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          error_count;
  int          pending_count;
  int          idle_cycles = 0;
  int          rx_cycle = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  logic [2:0]  insert_ops [3] = '{OP_APPEND, OP_PREPEND, OP_SORTED};

  always #5 clk = ~clk;

  ordered_list_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  ordered_list_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  task automatic send_item(input logic [2:0] op, input logic [31:0] value);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tuser  <= 3'($urandom);
    in_tdata  <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4, 5, 6: return 32'($urandom_range(0, 31)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input phase_t phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        if (r < 80) return insert_ops[$urandom_range(0, 2)];
        if (r < 95) return 3'($urandom_range(OP_REMOVE, OP_POP_LAST));
        return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      PH_DRAIN: begin
        if (r < 20) return insert_ops[$urandom_range(0, 2)];
        if (r < 95) return 3'($urandom_range(OP_REMOVE, OP_POP_LAST));
        return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:     out_tready <= 1'b1;
        RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_tready <= (rx_cycle % 4 != 0);
        default:     out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int     sent;
    int     burst;
    int     gap;
    int     phase_left;
    phase_t phase;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(OP_POP_FIRST, $urandom);
    send_item(OP_POP_LAST, $urandom);
    send_item(OP_REMOVE, 32'd0);
    send_item(OP_SPARE_LO, $urandom);
    send_item(OP_APPEND, 32'h7FFF_FFFF);
    send_item(OP_APPEND, 32'h8000_0000);
    send_item(OP_PREPEND, 32'd0);
    send_item(OP_SORTED, 32'hFFFF_FFFF);
    send_item(OP_SORTED, 32'h7FFF_FFFF);
    send_item(OP_REMOVE, 32'h8000_0000);
    send_item(OP_REMOVE, 32'd12345);
    for (int k = 0; k < 12; k++) send_item(insert_ops[k % 3], pick_value());
    send_item(OP_SORTED, pick_value());
    send_item(OP_POP_LAST, $urandom);

    sent = 0;
    phase_left = 0;
    phase = PH_MIXED;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst; k++) begin
        if (phase_left == 0) begin
          phase = phase_t'($urandom_range(0, 2));
          phase_left = $urandom_range(20, 60);
        end
        send_item(pick_op(phase), pick_value());
        phase_left--;
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_gap(gap);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
design/olist_pkg.sv
design/olist_cell.sv
design/ordered_list_engine.sv
dv/ordered_list_checker.sv
dv/ordered_list_engine_test.sv
